// File: rtl/core/rmq_pkg.sv
package rmq_pkg;

    // Fixed field widths
    localparam int ELEM_W    = 16;
    localparam int NUM_W     = 17;
    localparam int RAD_W     = 17;
    localparam int SQ_STEPS  = 16;
    localparam int DIV_STEPS = 16;

    // Branch codes
    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_X     = 2'd1;
    localparam logic [1:0] BR_Y     = 2'd2;
    localparam logic [1:0] BR_Z     = 2'd3;

    typedef logic signed [NUM_W-1:0] num_t;

    // Per-item data that rides along with the square root
    typedef struct packed {
        logic [1:0] br;
        logic       deg;
        num_t       n0;
        num_t       n1;
        num_t       n2;
    } side_t;

endpackage

// File: rtl/core/rmq_mat_if.sv
interface rmq_mat_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;

    modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    input ready);
    modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  output ready);
endinterface

// File: rtl/core/rmq_quat_if.sv
interface rmq_quat_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic [1:0]         branch_taken;
    logic               degenerate;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, branch_taken, degenerate,
                    input ready);
    modport sink (input valid, quat_w, quat_x, quat_y, quat_z, branch_taken, degenerate,
                  output ready);
endinterface

// File: rtl/core/rmq_front.sv
module rmq_front
    import rmq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_vld,
    input  logic signed [15:0] r00,
    input  logic signed [15:0] r01,
    input  logic signed [15:0] r02,
    input  logic signed [15:0] r10,
    input  logic signed [15:0] r11,
    input  logic signed [15:0] r12,
    input  logic signed [15:0] r20,
    input  logic signed [15:0] r21,
    input  logic signed [15:0] r22,
    output logic               vld,
    output logic [RAD_W-1:0]   rad,
    output side_t              side
);

    logic signed [18:0] e00, e11, e22;
    logic signed [18:0] trace;
    logic signed [18:0] rad_s;
    logic [1:0]         br;
    logic               deg;
    num_t               d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;
    side_t              side_next;
    logic [RAD_W-1:0]   rad_next;
    logic               vld_reg;
    logic [RAD_W-1:0]   rad_reg;
    side_t              side_reg;

    assign e00 = {{3{r00[15]}}, r00};
    assign e11 = {{3{r11[15]}}, r11};
    assign e22 = {{3{r22[15]}}, r22};
    assign trace = e00 + e11 + e22;

    // Off-diagonal sums and differences
    assign d21_12 = {r21[15], r21} - {r12[15], r12};
    assign d02_20 = {r02[15], r02} - {r20[15], r20};
    assign d10_01 = {r10[15], r10} - {r01[15], r01};
    assign s01_10 = {r01[15], r01} + {r10[15], r10};
    assign s02_20 = {r02[15], r02} + {r20[15], r20};
    assign s12_21 = {r12[15], r12} + {r21[15], r21};

    // Branch pick and radicand; numerators packed in w,x,y,z order minus the diagonal
    always_comb
    begin
        side_next = '0;
        if (trace > 19'sd0)
        begin
            br    = BR_TRACE;
            rad_s = 19'sd16384 + trace;
            side_next.n0 = d21_12;
            side_next.n1 = d02_20;
            side_next.n2 = d10_01;
        end
        else if (r00 > r11 && r00 > r22)
        begin
            br    = BR_X;
            rad_s = 19'sd16384 + e00 - e11 - e22;
            side_next.n0 = d21_12;
            side_next.n1 = s01_10;
            side_next.n2 = s02_20;
        end
        else if (r11 > r22)
        begin
            br    = BR_Y;
            rad_s = 19'sd16384 + e11 - e00 - e22;
            side_next.n0 = d02_20;
            side_next.n1 = s01_10;
            side_next.n2 = s12_21;
        end
        else
        begin
            br    = BR_Z;
            rad_s = 19'sd16384 + e22 - e00 - e11;
            side_next.n0 = d10_01;
            side_next.n1 = s02_20;
            side_next.n2 = s12_21;
        end
        deg = rad_s[18] || (rad_s == 19'sd0);
        side_next.br  = br;
        side_next.deg = deg;
        rad_next = deg ? '0 : rad_s[RAD_W-1:0];
    end

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_reg  <= rad_next;
            side_reg <= side_next;
        end
    end

    assign vld  = vld_reg;
    assign rad  = rad_reg;
    assign side = side_reg;

endmodule

// File: rtl/core/rmq_sqrt.sv
module rmq_sqrt
    import rmq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_vld,
    input  logic [RAD_W-1:0] rad,
    input  side_t            in_side,
    output logic             vld,
    output logic [15:0]      q,
    output side_t            side
);

    // One result bit per stage, two radicand bits consumed per stage
    logic        vld_reg  [SQ_STEPS];
    logic [31:0] v_reg    [SQ_STEPS];
    logic [17:0] rem_reg  [SQ_STEPS];
    logic [15:0] root_reg [SQ_STEPS];
    side_t       side_reg [SQ_STEPS];

    for (genvar s = 0; s < SQ_STEPS; s++)
    begin : g_step
        logic        vld_src;
        logic [31:0] v_src;
        logic [17:0] rem_src;
        logic [15:0] root_src;
        side_t       side_src;
        logic [19:0] rem_sh;
        logic [19:0] trial;
        logic [19:0] diff;
        logic        take;

        if (s == 0)
        begin : g_first
            assign vld_src  = in_vld;
            assign v_src    = {1'b0, rad, 14'b0};
            assign rem_src  = '0;
            assign root_src = '0;
            assign side_src = in_side;
        end
        else
        begin : g_next
            assign vld_src  = vld_reg[s-1];
            assign v_src    = v_reg[s-1];
            assign rem_src  = rem_reg[s-1];
            assign root_src = root_reg[s-1];
            assign side_src = side_reg[s-1];
        end

        // Trial subtraction of 4*root+1
        assign rem_sh = {rem_src, v_src[31-2*s -: 2]};
        assign trial  = {2'b00, root_src, 2'b01};
        assign diff   = rem_sh - trial;
        assign take   = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[s] <= vld_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                v_reg[s]    <= v_src;
                rem_reg[s]  <= take ? diff[17:0] : rem_sh[17:0];
                root_reg[s] <= {root_src[14:0], take};
                side_reg[s] <= side_src;
            end
        end
    end

    assign vld  = vld_reg[SQ_STEPS-1];
    assign q    = root_reg[SQ_STEPS-1];
    assign side = side_reg[SQ_STEPS-1];

endmodule

// File: rtl/core/rmq_div.sv
module rmq_div
    import rmq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_vld,
    input  logic [15:0]        in_q,
    input  side_t              in_side,
    output logic               vld,
    output logic [15:0]        q,
    output side_t              side,
    output logic signed [15:0] c0,
    output logic signed [15:0] c1,
    output logic signed [15:0] c2
);

    localparam int LANES = 3;

    // Stage 0 prepares the dividends, stages 1..DIV_STEPS each resolve one quotient bit
    logic        vld_reg  [DIV_STEPS+1];
    logic [15:0] q_reg    [DIV_STEPS+1];
    side_t       side_reg [DIV_STEPS+1];
    logic [29:0] p_reg    [LANES][DIV_STEPS+1];
    logic [15:0] quo_reg  [LANES][DIV_STEPS+1];
    logic        neg_reg  [LANES][DIV_STEPS+1];
    logic        ovf_reg  [LANES][DIV_STEPS+1];
    logic signed [15:0] res [LANES];
    num_t        num_in   [LANES];

    assign num_in[0] = in_side.n0;
    assign num_in[1] = in_side.n1;
    assign num_in[2] = in_side.n2;

    // Shared control and divisor
    for (genvar s = 0; s <= DIV_STEPS; s++)
    begin : g_ctl
        logic  vld_src;
        logic [15:0] q_src;
        side_t side_src;

        if (s == 0)
        begin : g_first
            assign vld_src  = in_vld;
            assign q_src    = in_q;
            assign side_src = in_side;
        end
        else
        begin : g_next
            assign vld_src  = vld_reg[s-1];
            assign q_src    = q_reg[s-1];
            assign side_src = side_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[s] <= vld_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                q_reg[s]    <= q_src;
                side_reg[s] <= side_src;
            end
        end
    end

    for (genvar j = 0; j < LANES; j++)
    begin : g_lane
        logic [NUM_W-1:0] mag;
        logic [29:0]      dvd;

        // Magnitude scaled by 2^13 plus half the divisor for rounding
        assign mag = num_in[j][NUM_W-1] ? (~num_in[j] + 1'b1) : num_in[j];
        assign dvd = {mag, 13'b0} + {15'b0, in_q[15:1]};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                p_reg[j][0]   <= dvd;
                quo_reg[j][0] <= '0;
                neg_reg[j][0] <= num_in[j][NUM_W-1];
                ovf_reg[j][0] <= ({2'b00, dvd} >= {in_q, 16'b0});
            end
        end

        for (genvar s = 1; s <= DIV_STEPS; s++)
        begin : g_step
            localparam int K = DIV_STEPS - s;
            logic [31:0] sub;
            logic        take;

            assign sub  = {16'b0, q_reg[s-1]} << K;
            assign take = ({2'b00, p_reg[j][s-1]} >= sub);

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    p_reg[j][s]   <= take ? (p_reg[j][s-1] - sub[29:0]) : p_reg[j][s-1];
                    quo_reg[j][s] <= quo_reg[j][s-1] | ({15'b0, take} << K);
                    neg_reg[j][s] <= neg_reg[j][s-1];
                    ovf_reg[j][s] <= ovf_reg[j][s-1];
                end
            end
        end

        // Sign and saturation
        always_comb
        begin
            if (neg_reg[j][DIV_STEPS])
            begin
                if (ovf_reg[j][DIV_STEPS] || quo_reg[j][DIV_STEPS] > 16'd32768)
                begin
                    res[j] = 16'sh8000;
                end
                else
                begin
                    res[j] = ~quo_reg[j][DIV_STEPS] + 16'd1;
                end
            end
            else
            begin
                if (ovf_reg[j][DIV_STEPS] || quo_reg[j][DIV_STEPS][15])
                begin
                    res[j] = 16'sh7FFF;
                end
                else
                begin
                    res[j] = quo_reg[j][DIV_STEPS];
                end
            end
        end
    end

    assign vld  = vld_reg[DIV_STEPS];
    assign q    = q_reg[DIV_STEPS];
    assign side = side_reg[DIV_STEPS];
    assign c0   = res[0];
    assign c1   = res[1];
    assign c2   = res[2];

endmodule

// File: rtl/core/rotation_matrix_to_quaternion.sv
// Rotation matrix to unit quaternion, four-branch trace method.
//
// Channels: mat (sink) takes one 3x3 matrix of signed Q2.14 entries per
// transaction; quat (source) gives the quaternion w,x,y,z in signed Q2.14,
// the branch used and a degenerate flag, one result per matrix, in order.
//
// Pipeline from mat to quat: one stage for branch pick and radicand,
// 16 square-root stages (one root bit each), one dividend setup stage,
// 16 divider stages (one quotient bit each, three dividers side by side),
// and the output register. Throughput: one matrix per cycle unless quat
// stalls; every stage is a register with a valid bit.
//
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When quat stalls with a result waiting, the whole pipeline holds in place
// and mat.ready drops; nothing is dropped or repeated. mat.ready is high
// whenever the output register is empty or being emptied.
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rmq_mat_if.sink    mat,
    rmq_quat_if.source quat
);

    logic               adv;
    logic               f_vld;
    logic [RAD_W-1:0]   f_rad;
    side_t              f_side;
    logic               s_vld;
    logic [15:0]        s_q;
    side_t              s_side;
    logic               d_vld;
    logic [15:0]        d_q;
    side_t              d_side;
    logic signed [15:0] c0, c1, c2;
    logic [16:0]        diag_sum;
    logic signed [15:0] diag;
    logic signed [15:0] w_next, x_next, y_next, z_next;

    logic               out_vld_reg;
    logic signed [15:0] w_reg, x_reg, y_reg, z_reg;
    logic [1:0]         br_reg;
    logic               deg_reg;

    // Global advance: the pipeline moves unless the output is held
    assign adv       = !out_vld_reg || quat.ready;
    assign mat.ready = adv;

    rmq_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .in_vld (mat.valid),
        .r00    (mat.r00),
        .r01    (mat.r01),
        .r02    (mat.r02),
        .r10    (mat.r10),
        .r11    (mat.r11),
        .r12    (mat.r12),
        .r20    (mat.r20),
        .r21    (mat.r21),
        .r22    (mat.r22),
        .vld    (f_vld),
        .rad    (f_rad),
        .side   (f_side)
    );

    rmq_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (f_vld),
        .rad     (f_rad),
        .in_side (f_side),
        .vld     (s_vld),
        .q       (s_q),
        .side    (s_side)
    );

    rmq_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (s_vld),
        .in_q    (s_q),
        .in_side (s_side),
        .vld     (d_vld),
        .q       (d_q),
        .side    (d_side),
        .c0      (c0),
        .c1      (c1),
        .c2      (c2)
    );

    // Diagonal component: q/2 rounded half up
    assign diag_sum = {1'b0, d_q} + 17'd1;
    assign diag     = diag_sum[16:1];

    // Put the diagonal back in its slot
    always_comb
    begin
        case (d_side.br)
            BR_TRACE:
            begin
                w_next = diag; x_next = c0;   y_next = c1;   z_next = c2;
            end
            BR_X:
            begin
                w_next = c0;   x_next = diag; y_next = c1;   z_next = c2;
            end
            BR_Y:
            begin
                w_next = c0;   x_next = c1;   y_next = diag; z_next = c2;
            end
            default:
            begin
                w_next = c0;   x_next = c1;   y_next = c2;   z_next = diag;
            end
        endcase
        if (d_side.deg)
        begin
            w_next = '0; x_next = '0; y_next = '0; z_next = '0;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= d_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_reg   <= w_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            br_reg  <= d_side.br;
            deg_reg <= d_side.deg;
        end
    end

    assign quat.valid        = out_vld_reg;
    assign quat.quat_w       = w_reg;
    assign quat.quat_x       = x_reg;
    assign quat.quat_y       = y_reg;
    assign quat.quat_z       = z_reg;
    assign quat.branch_taken = br_reg;
    assign quat.degenerate   = deg_reg;

`ifndef SYNTHESIS
    // A degenerate result carries an all-zero quaternion
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && deg_reg |->
            w_reg == 16'sd0 && x_reg == 16'sd0 && y_reg == 16'sd0 && z_reg == 16'sd0)
        else $error("degenerate result with nonzero quaternion");

    // The component of the chosen branch is strictly positive when not degenerate
    a_diag_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !deg_reg |->
            (br_reg == BR_TRACE && w_reg > 16'sd0) || (br_reg == BR_X && x_reg > 16'sd0) ||
            (br_reg == BR_Y && y_reg > 16'sd0) || (br_reg == BR_Z && z_reg > 16'sd0))
        else $error("diagonal component not positive");

    // The trace branch never sees a non-positive radicand
    a_trace_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && br_reg == BR_TRACE |-> !deg_reg)
        else $error("trace branch flagged degenerate");
`endif

endmodule

// File: tb/rotation_matrix_to_quaternion_tb.sv
`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_tb;
    import rmq_pkg::*;

    typedef struct {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [1:0]         br;
        logic               deg;
    } quat_rec_t;

    localparam int LATENCY   = 35;
    localparam int WDOG_MAX  = 20000;

    logic clk;
    logic rst_n;

    rmq_mat_if  mat ();
    rmq_quat_if quat ();

    rotation_matrix_to_quaternion DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .mat   (mat.sink),
        .quat  (quat.source)
    );

    quat_rec_t quat_expected[$];
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        hold_off;
    int        error_count;
    int        matrices_sent;
    int        quats_checked;
    int        branch_seen[4];
    int        deg_seen;
    int        wdog;

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Integer square root, floor
    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[15:0];
    endfunction

    // n * 2^13 / q, nearest, ties away from zero
    function automatic logic signed [15:0] scaled_quotient(longint n, longint unsigned q);
        longint unsigned mag;
        longint unsigned r;
        mag = (n < 0) ? -n : n;
        r = ((mag << 13) + (q >> 1)) / q;
        return clamp16((n < 0) ? -longint'(r) : longint'(r));
    endfunction

    // Predicted quaternion for one matrix
    function automatic quat_rec_t predict_quat(logic signed [15:0] m[9]);
        quat_rec_t       res;
        longint          tr;
        longint          rad;
        longint          num[4];
        longint unsigned q;
        logic signed [15:0] comp[4];
        tr = m[0] + m[4] + m[8];
        num = '{0, 0, 0, 0};
        if (tr > 0)
        begin
            res.br = BR_TRACE;
            rad = 16384 + tr;
            num[1] = m[7] - m[5]; num[2] = m[2] - m[6]; num[3] = m[3] - m[1];
        end
        else if (m[0] > m[4] && m[0] > m[8])
        begin
            res.br = BR_X;
            rad = 16384 + m[0] - m[4] - m[8];
            num[0] = m[7] - m[5]; num[2] = m[1] + m[3]; num[3] = m[2] + m[6];
        end
        else if (m[4] > m[8])
        begin
            res.br = BR_Y;
            rad = 16384 + m[4] - m[0] - m[8];
            num[0] = m[2] - m[6]; num[1] = m[1] + m[3]; num[3] = m[5] + m[7];
        end
        else
        begin
            res.br = BR_Z;
            rad = 16384 + m[8] - m[0] - m[4];
            num[0] = m[3] - m[1]; num[1] = m[2] + m[6]; num[2] = m[5] + m[7];
        end
        comp = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
        res.deg = (rad <= 0);
        if (!res.deg)
        begin
            q = isqrt(longint'(rad) << 14);
            for (int i = 0; i < 4; i++)
                comp[i] = (i == res.br) ? clamp16((q + 1) >> 1) : scaled_quotient(num[i], q);
        end
        res.w = comp[0]; res.x = comp[1]; res.y = comp[2]; res.z = comp[3];
        return res;
    endfunction

    // Offer one matrix and wait for its transaction
    task automatic send_matrix(logic signed [15:0] m[9]);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            mat.valid <= 1'b0;
            @(posedge clk);
        end
        mat.valid <= 1'b1;
        mat.r00 <= m[0]; mat.r01 <= m[1]; mat.r02 <= m[2];
        mat.r10 <= m[3]; mat.r11 <= m[4]; mat.r12 <= m[5];
        mat.r20 <= m[6]; mat.r21 <= m[7]; mat.r22 <= m[8];
        do
            @(posedge clk);
        while (!mat.ready);
        quat_expected.push_back(predict_quat(m));
        matrices_sent++;
    endtask

    task automatic go_idle();
        mat.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random rotation-like matrix: a permutation with signs, entries jittered
    function automatic void near_rotation(output logic signed [15:0] m[9], input int jit);
        int p[3];
        int k;
        p = '{0, 1, 2};
        for (int i = 2; i > 0; i--)
        begin
            k = $urandom_range(i);
            {p[i], p[k]} = {p[k], p[i]};
        end
        for (int i = 0; i < 9; i++)
            m[i] = $signed(16'($urandom_range(2 * jit))) - 16'(jit);
        for (int i = 0; i < 3; i++)
            m[3 * i + p[i]] = 16'(($urandom_range(1) ? 16384 : -16384) + m[3 * i + p[i]] / 2);
    endfunction

    task automatic test_directed();
        logic signed [15:0] m[9];
        // identity and the three half-turns
        m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; send_matrix(m);
        m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(m);
        m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; send_matrix(m);
        m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; send_matrix(m);
        // 90 degree turns about z and x
        m = '{0, -16384, 0, 16384, 0, 0, 0, 0, 16384}; send_matrix(m);
        m = '{16384, 0, 0, 0, 0, -16384, 0, 16384, 0}; send_matrix(m);
        // ties on the diagonal, zero trace
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(m);
        m = '{-8192, 100, 0, 0, -8192, 0, 0, 0, 16384}; send_matrix(m);
        m = '{5000, 0, 0, 0, 5000, 0, 0, 0, -10000}; send_matrix(m);
        // extremes: all max, all min, then mixed cases
        m = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}; send_matrix(m);
        m = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
        send_matrix(m);
        m = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
        send_matrix(m);
        m = '{-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767, 32767};
        send_matrix(m);
        m = '{-1, 0, 0, 0, 32767, 0, 0, 0, 32767}; send_matrix(m);
        // large off-diagonals on the z branch
        m = '{-16383, 32767, -32768, -32768, -16384, 32767, 32767, -32768, 16384};
        send_matrix(m);
        m = '{-16384, -32768, 32767, 32767, -16384, -32768, -32768, 32767, 16383};
        send_matrix(m);
        go_idle();
    endtask

    task automatic test_random(int count);
        logic signed [15:0] m[9];
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 70)
                near_rotation(m, $urandom_range(1) ? 200 : 8000);
            else
                for (int i = 0; i < 9; i++)
                    m[i] = 16'($urandom);
            send_matrix(m);
        end
        go_idle();
    endtask

    // Receiver long hold-off while matrices keep coming
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            test_random(60);
            begin
                repeat (150) @(posedge clk);
                hold_off = 1'b0;
            end
        join
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (quat_expected.size() != 0 && guard < WDOG_MAX)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // Receiver ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quat.ready <= 1'b0;
        else
            quat.ready <= !hold_off && !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        quat_rec_t e;
        if (rst_n && quat.valid && quat.ready)
        begin
            if (quat_expected.size() == 0)
            begin
                $display("%0t: unexpected quaternion w=%0d x=%0d y=%0d z=%0d", $time,
                         quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z);
                error_count++;
            end
            else
            begin
                e = quat_expected.pop_front();
                quats_checked++;
                branch_seen[e.br]++;
                if (e.deg)
                    deg_seen++;
                if (quat.quat_w !== e.w || quat.quat_x !== e.x || quat.quat_y !== e.y ||
                    quat.quat_z !== e.z || quat.branch_taken !== e.br ||
                    quat.degenerate !== e.deg)
                begin
                    $display("%0t: mismatch expected w=%0d x=%0d y=%0d z=%0d br=%0d deg=%0d",
                             $time, e.w, e.x, e.y, e.z, e.br, e.deg);
                    $display("%0t:          actual   w=%0d x=%0d y=%0d z=%0d br=%0d deg=%0d",
                             $time, quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z,
                             quat.branch_taken, quat.degenerate);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((mat.valid && mat.ready) || (quat.valid && quat.ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX)
        begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     quat_expected.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        mat.valid = 1'b0;
        {mat.r00, mat.r01, mat.r02, mat.r10, mat.r11, mat.r12, mat.r20, mat.r21, mat.r22} = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        error_count = 0;
        matrices_sent = 0;
        quats_checked = 0;
        deg_seen = 0;
        wdog = 0;
        branch_seen = '{0, 0, 0, 0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(200);
        send_idle_pct = 58;
        test_random(200);
        send_idle_pct = 0;
        recv_stall_pct = 58;
        test_random(200);
        send_idle_pct = 35;
        recv_stall_pct = 35;
        test_random(170);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();
        drain();

        if (quat_expected.size() != 0)
        begin
            $display("%0d expected quaternions never arrived", quat_expected.size());
            error_count++;
        end
        $display("Sent %0d matrices, checked %0d quaternions, %0d degenerate.",
                 matrices_sent, quats_checked, deg_seen);
        $display("Branches trace/x/y/z: %0d/%0d/%0d/%0d, with idle, stall and hold-off phases.",
                 branch_seen[0], branch_seen[1], branch_seen[2], branch_seen[3]);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/rmq_pkg.sv
rtl/core/rmq_mat_if.sv
rtl/core/rmq_quat_if.sv
rtl/core/rmq_front.sv
rtl/core/rmq_sqrt.sv
rtl/core/rmq_div.sv
rtl/core/rotation_matrix_to_quaternion.sv
tb/rotation_matrix_to_quaternion_tb.sv
